FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tracking table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg
// Types and constants of the transaction tracking table.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 256;
    localparam int unsigned MAX_COMMANDS    = 32;
    localparam int unsigned MS_PER_S        = 1000;
    localparam logic [31:0] DEF_TIMEOUT_MS  = 32'd30000;

    localparam int unsigned OP_W    = 4;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned TYPE_W  = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned CMD_W   = 6;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned PROD_W  = 42;

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE    = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD_CMD   = 4'd1;
    localparam logic [OP_W-1:0] OP_SEND      = 4'd2;
    localparam logic [OP_W-1:0] OP_REPLY     = 4'd3;
    localparam logic [OP_W-1:0] OP_GET_STATE = 4'd4;
    localparam logic [OP_W-1:0] OP_CANCEL    = 4'd5;
    localparam logic [OP_W-1:0] OP_SCAN      = 4'd6;
    localparam logic [OP_W-1:0] OP_GET_COUNT = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

    // entry states
    localparam logic [ST_W-1:0] ES_IDLE    = 2'd0;
    localparam logic [ST_W-1:0] ES_PENDING = 2'd1;
    localparam logic [ST_W-1:0] ES_REPLIED = 2'd2;
    localparam logic [ST_W-1:0] ES_ERROR   = 2'd3;

    // configuration register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_ENABLE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] msg_type;
        logic [ST_W-1:0]   state;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] timeout;
        logic [CMD_W-1:0]  cmd_count;
    } t_entry;

    typedef struct packed {
        logic              status;
        logic [ID_W-1:0]   result_id;
        logic [ST_W-1:0]   entry_state;
        logic [TYPE_W-1:0] entry_type;
        logic [CMD_W-1:0]  command_total;
        logic [COUNT_W-1:0] count;
    } t_result;

    // memory write port bundle
    typedef struct packed {
        logic   we;
        t_entry wdata;
    } t_wr;

endpackage

FILE: design/tt_ifs.sv
// ----------------------------------------------------------------------------
// tt interfaces
// Request, response and configuration channels of the tracking table.
// ----------------------------------------------------------------------------
interface tt_req_if
    import tt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   txn_id;
    logic [TYPE_W-1:0] msg_type;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, operation, txn_id, msg_type, now_seconds, input ready);
    modport sink   (input valid, operation, txn_id, msg_type, now_seconds, output ready);
endinterface

interface tt_rsp_if
    import tt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               status;
    logic [ID_W-1:0]    result_id;
    logic [ST_W-1:0]    entry_state;
    logic [TYPE_W-1:0]  entry_type;
    logic [CMD_W-1:0]   command_total;
    logic [COUNT_W-1:0] count;

    modport source (output valid, status, result_id, entry_state, entry_type,
                    command_total, count, input ready);
    modport sink   (input valid, status, result_id, entry_state, entry_type,
                    command_total, count, output ready);
endinterface

interface tt_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/transaction_tracking_table_unit.sv
// Create, get_count, clear and disabled requests go from idle straight to S_DONE.
// Lookups walk the table through S_RD and S_CHK per entry up to the first match; a
// timeout scan steps through S_RD, S_CHK, S_MUL and S_WB for every used entry.
// One request at a time; the entry memory's single read port sets the walk rate.
// Reset: table empty, next id 1, timeout 30000 ms, enabled; no memory clearing pass.
// ----------------------------------------------------------------------------
// transaction_tracking_table_unit
// Table of outstanding transactions with id lookup and timeout scan.
// ----------------------------------------------------------------------------
module transaction_tracking_table_unit
    import tt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tt_req_if.sink   i_req,
    tt_rsp_if.source o_rsp,
    tt_cfg_if.sink   i_cfg
);

`include "assert_macros.svh"

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_MUL, S_WB, S_DONE
    } t_state;

    t_state            r_state;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now;
    logic [AW-1:0]     r_idx;
    logic [UW-1:0]     r_used;
    logic [UW-1:0]     r_hits;
    logic [ID_W-1:0]   r_next_id;
    logic [31:0]       r_timeout;
    logic              r_enable;
    logic [PROD_W-1:0] r_prod;
    t_result           r_res;
    t_result           r_out;
    logic              r_ovalid;

    t_wr           mem_wr;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    t_entry        rdata;

    logic          req_acc;
    logic          out_free;
    logic          last_entry;
    logic [UW-1:0] idx_next;
    logic [31:0]   elapsed;
    logic [TIME_W-1:0] elapsed_s;
    logic [ID_W-1:0] id_inc;
    t_entry        new_ent;
    t_entry        mod_ent;
    t_result       fail_res;
    t_result       n_res;
    logic          start_walk;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign idx_next    = UW'(r_idx) + UW'(1);
    assign last_entry  = (idx_next >= r_used);
    assign id_inc      = (r_next_id == '1) ? ID_W'(1) : r_next_id + ID_W'(1);
    assign elapsed     = (|r_prod[PROD_W-1:32]) ? '1 : r_prod[31:0];
    // seconds since start, modulo 2^32
    assign elapsed_s   = r_now - rdata.start;

    assign mem_re = (r_state == S_RD);

    // result and walk decision for a request accepted while idle
    always_comb begin
        n_res        = '0;
        n_res.status = STATUS_FAIL;
        start_walk   = 1'b0;
        if (i_req.operation == OP_CLEAR) begin
            n_res.status = STATUS_OK;
        end else if (r_enable) begin
            case (i_req.operation)
                OP_CREATE: begin
                    if (r_used < UW'(TABLE_DEPTH)) begin
                        n_res.status      = STATUS_OK;
                        n_res.result_id   = r_next_id;
                        n_res.entry_state = ES_PENDING;
                        n_res.entry_type  = i_req.msg_type;
                    end
                end
                OP_ADD_CMD, OP_SEND, OP_REPLY, OP_GET_STATE, OP_CANCEL: begin
                    n_res.result_id = i_req.txn_id;
                    start_walk      = (r_used != '0);
                end
                OP_SCAN: begin
                    n_res.status = STATUS_OK;
                    start_walk   = (r_used != '0);
                end
                OP_GET_COUNT: begin
                    n_res.status = STATUS_OK;
                    n_res.count  = COUNT_W'(r_used);
                end
                default: n_res.status = STATUS_FAIL;
            endcase
        end
    end

    always_comb begin
        new_ent.id        = r_next_id;
        new_ent.msg_type  = i_req.msg_type;
        new_ent.state     = ES_PENDING;
        new_ent.start     = i_req.now_seconds;
        new_ent.timeout   = r_timeout;
        new_ent.cmd_count = '0;

        mod_ent = rdata;
        case (r_op)
            OP_ADD_CMD: begin
                if (rdata.cmd_count < CMD_W'(MAX_COMMANDS)) begin
                    mod_ent.cmd_count = rdata.cmd_count + CMD_W'(1);
                end
            end
            OP_SEND: begin
                mod_ent.state = ES_PENDING;
                mod_ent.start = r_now;
            end
            OP_REPLY:  mod_ent.state = ES_REPLIED;
            OP_CANCEL: mod_ent.state = ES_IDLE;
            default:   mod_ent = rdata;
        endcase

        fail_res           = '0;
        fail_res.status    = STATUS_FAIL;
        fail_res.result_id = r_id;

        mem_wr.we    = 1'b0;
        mem_wr.wdata = mod_ent;
        mem_waddr    = r_idx;
        if (req_acc && r_enable && i_req.operation == OP_CREATE
                && r_used < UW'(TABLE_DEPTH)) begin
            mem_wr.we    = 1'b1;
            mem_wr.wdata = new_ent;
            mem_waddr    = r_used[AW-1:0];
        end else if (r_state == S_CHK && r_op != OP_SCAN && rdata.id == r_id
                && r_op != OP_GET_STATE) begin
            mem_wr.we = 1'b1;
        end else if (r_state == S_WB && rdata.state == ES_PENDING
                && elapsed >= rdata.timeout) begin
            mem_wr.we          = 1'b1;
            mem_wr.wdata       = rdata;
            mem_wr.wdata.state = ES_ERROR;
        end
    end

    tt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_waddr (mem_waddr),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_next_id <= ID_W'(1);
            r_timeout <= DEF_TIMEOUT_MS;
            r_enable  <= 1'b1;
            r_ovalid  <= 1'b0;
            r_hits    <= '0;
            r_idx     <= '0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_op    <= i_req.operation;
                        r_id    <= i_req.txn_id;
                        r_now   <= i_req.now_seconds;
                        r_idx   <= '0;
                        r_hits  <= '0;
                        r_res   <= n_res;
                        r_state <= start_walk ? S_RD : S_DONE;
                        if (i_req.operation == OP_CLEAR) begin
                            r_used <= '0;
                        end else if (r_enable && i_req.operation == OP_CREATE
                                && r_used < UW'(TABLE_DEPTH)) begin
                            r_used    <= r_used + UW'(1);
                            r_next_id <= id_inc;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_op == OP_SCAN) begin
                        r_prod  <= PROD_W'(elapsed_s) * PROD_W'(MS_PER_S);
                        r_state <= S_MUL;
                    end else if (rdata.id == r_id) begin
                        r_res.status <= (r_op == OP_ADD_CMD
                            && rdata.cmd_count >= CMD_W'(MAX_COMMANDS))
                            ? STATUS_FAIL : STATUS_OK;
                        r_res.entry_state   <= mod_ent.state;
                        r_res.entry_type    <= mod_ent.msg_type;
                        r_res.command_total <= mod_ent.cmd_count;
                        r_state <= S_DONE;
                    end else if (last_entry) begin
                        r_res   <= fail_res;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= idx_next[AW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_MUL: r_state <= S_WB;
                S_WB: begin
                    if (mem_wr.we) begin
                        r_hits <= r_hits + UW'(1);
                    end
                    if (last_entry) begin
                        r_res.count <= COUNT_W'(r_hits + UW'(mem_wr.we));
                        r_state     <= S_DONE;
                    end else begin
                        r_idx   <= idx_next[AW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out    <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // config writes are to arrive only while idle; the block itself does not enforce it
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TIMEOUT: r_timeout <= i_cfg.data;
                    REG_ENABLE: begin
                        if (i_cfg.data[0] && !r_enable) begin
                            r_used    <= '0;
                            r_next_id <= ID_W'(1);
                        end
                        r_enable <= i_cfg.data[0];
                    end
                    default: r_enable <= r_enable;
                endcase
            end
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.result_id     = r_out.result_id;
    assign o_rsp.entry_state   = r_out.entry_state;
    assign o_rsp.entry_type    = r_out.entry_type;
    assign o_rsp.command_total = r_out.command_total;
    assign o_rsp.count         = r_out.count;

    `ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= UW'(TABLE_DEPTH), "used count overflow")
    `ASSERT_ALWAYS(a_id_nonzero, i_clk, i_rst_n, r_next_id != '0, "next id is zero")
    `ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state == S_RD, UW'(r_idx) < r_used, "walk past used entries")
    `ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == S_DONE && out_free, r_ovalid && r_state == S_IDLE, "result not loaded")

endmodule

FILE: design/tt_mem.sv
// ----------------------------------------------------------------------------
// tt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tt_mem
    import tt_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_TABLE_DEPTH,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  t_wr           i_wr,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: dv/tt_scoreboard.sv
// ----------------------------------------------------------------------------
// tt_scoreboard
// Tracking-table predictor and in-order checker of response fields.
// ----------------------------------------------------------------------------
import tt_pkg::*;

class tt_scoreboard;

    // predicted table contents
    logic [ID_W-1:0]   tbl_id [DEF_TABLE_DEPTH];
    logic [TYPE_W-1:0] tbl_type [DEF_TABLE_DEPTH];
    logic [ST_W-1:0]   tbl_state [DEF_TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_start [DEF_TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_timeout [DEF_TABLE_DEPTH];
    logic [CMD_W-1:0]  tbl_cmds [DEF_TABLE_DEPTH];
    int unsigned       used;
    logic [ID_W-1:0]   next_id;
    logic [31:0]       timeout_ms;
    logic              enabled;

    t_result     pending_rsp[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned expired_seen;

    function new();
        used = 0;
        next_id = 1;
        timeout_ms = DEF_TIMEOUT_MS;
        enabled = 1'b1;
        mismatches = 0;
        checked = 0;
        expired_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
        if (idx == REG_TIMEOUT) begin
            timeout_ms = data;
        end else begin
            if (data[0] && !enabled) begin
                used = 0;
                next_id = 1;
            end
            enabled = data[0];
        end
    endfunction

    function int find(logic [ID_W-1:0] id);
        for (int i = 0; i < used; i++)
            if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    // note an accepted request and queue its predicted response
    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [TYPE_W-1:0] mtype, logic [TIME_W-1:0] now);
        t_result r;
        int idx;
        int unsigned hits;
        logic [63:0] el;
        logic [TIME_W-1:0] dt;
        r = '0;
        r.status = STATUS_FAIL;
        if (op == OP_CLEAR) begin
            used = 0;
            r.status = STATUS_OK;
        end else if (enabled && op <= OP_CLEAR) begin
            if (op >= OP_ADD_CMD && op <= OP_CANCEL) r.result_id = id;
            case (op)
                OP_CREATE: begin
                    if (used < DEF_TABLE_DEPTH) begin
                        idx = used;
                        used++;
                        tbl_id[idx] = next_id;
                        next_id++;
                        if (next_id == 0) next_id = 1;
                        tbl_type[idx] = mtype;
                        tbl_state[idx] = ES_PENDING;
                        tbl_start[idx] = now;
                        tbl_timeout[idx] = timeout_ms;
                        tbl_cmds[idx] = '0;
                        r.status = STATUS_OK;
                        r.result_id = tbl_id[idx];
                        r.entry_state = ES_PENDING;
                        r.entry_type = mtype;
                    end
                end
                OP_SCAN: begin
                    hits = 0;
                    for (int i = 0; i < used; i++) begin
                        if (tbl_state[i] == ES_PENDING) begin
                            dt = now - tbl_start[i];
                            el = 64'(dt) * MS_PER_S;
                            if (el > 64'hFFFF_FFFF) el = 64'hFFFF_FFFF;
                            if (el >= tbl_timeout[i]) begin
                                tbl_state[i] = ES_ERROR;
                                hits++;
                            end
                        end
                    end
                    expired_seen += hits;
                    r.status = STATUS_OK;
                    r.count = COUNT_W'(hits);
                end
                OP_GET_COUNT: begin
                    r.status = STATUS_OK;
                    r.count = COUNT_W'(used);
                end
                default: begin
                    idx = find(id);
                    if (idx >= 0) begin
                        r.status = STATUS_OK;
                        case (op)
                            OP_ADD_CMD: begin
                                if (tbl_cmds[idx] < MAX_COMMANDS) tbl_cmds[idx]++;
                                else r.status = STATUS_FAIL;
                            end
                            OP_SEND: begin
                                tbl_state[idx] = ES_PENDING;
                                tbl_start[idx] = now;
                            end
                            OP_REPLY:  tbl_state[idx] = ES_REPLIED;
                            OP_CANCEL: tbl_state[idx] = ES_IDLE;
                            default: ;
                        endcase
                        r.entry_state = tbl_state[idx];
                        r.entry_type = tbl_type[idx];
                        r.command_total = tbl_cmds[idx];
                    end
                end
            endcase
        end
        pending_rsp.push_back(r);
    endfunction

    function void check_response(t_result got);
        t_result exp;
        if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: response with none expected");
            return;
        end
        exp = pending_rsp.pop_front();
        checked++;
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: rsp %0d exp st=%0d id=%h es=%0d ty=%h cmd=%0d cnt=%0d",
                         checked, exp.status, exp.result_id, exp.entry_state,
                         exp.entry_type, exp.command_total, exp.count);
                $display("       got st=%0d id=%h es=%0d ty=%h cmd=%0d cnt=%0d",
                         got.status, got.result_id, got.entry_state,
                         got.entry_type, got.command_total, got.count);
            end
        end
    endfunction
endclass

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives create/lookup/scan traffic into the tracking table, with config
// changes between phases, random stalls on both sides, and checks responses.
// ----------------------------------------------------------------------------
module testbench;
    import tt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tt_req_if req_if();
    tt_rsp_if rsp_if();
    tt_cfg_if cfg_if();

    transaction_tracking_table_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source),
        .i_cfg  (cfg_if.sink)
    );

    tt_scoreboard sb = new();

    int unsigned req_idle_pct = 21;
    int unsigned rsp_idle_pct = 21;
    int unsigned rsp_hold = 0;
    int unsigned sent = 0;
    logic [TIME_W-1:0] clock_s = 0;
    logic [ID_W-1:0]   known_ids[$];

    always #2 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.operation = '0;
        req_if.txn_id = '0;
        req_if.msg_type = '0;
        req_if.now_seconds = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_TIMEOUT;
        cfg_if.data = '0;
        rsp_if.ready = 1'b0;
    end

    // response side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response({rsp_if.status, rsp_if.result_id, rsp_if.entry_state,
                                   rsp_if.entry_type, rsp_if.command_total, rsp_if.count});
            if (rsp_hold > 0) begin
                rsp_hold <= rsp_hold - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    // valid stays up after the accepting edge; callers that stop sending drop it
    task automatic send_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [TYPE_W-1:0] mt, logic [TIME_W-1:0] now);
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.txn_id <= id;
        req_if.msg_type <= mt;
        req_if.now_seconds <= now;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, id, mt, now);
        if (op == OP_CREATE && sb.pending_rsp[$].status == STATUS_OK)
            known_ids.push_back(sb.pending_rsp[$].result_id);
        sent++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4 * DEF_TABLE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int unsigned sel;
        sel = $urandom_range(9);
        if (known_ids.size() == 0 || sel == 0) return $urandom();
        if (sel == 1) return sb.next_id;
        return known_ids[$urandom_range(known_ids.size() - 1)];
    endfunction

    // mostly valid ops on live ids, time advancing in random steps
    task automatic random_phase(int n);
        logic [OP_W-1:0] op;
        int unsigned w;
        for (int k = 0; k < n; k++) begin
            w = $urandom_range(99);
            if (w < 20) op = OP_CREATE;
            else if (w < 36) op = OP_ADD_CMD;
            else if (w < 48) op = OP_SEND;
            else if (w < 58) op = OP_REPLY;
            else if (w < 72) op = OP_GET_STATE;
            else if (w < 78) op = OP_CANCEL;
            else if (w < 88) op = OP_SCAN;
            else if (w < 94) op = OP_GET_COUNT;
            else if (w < 96) op = OP_CLEAR;
            else op = OP_W'($urandom_range(15));
            clock_s += ($urandom_range(3) == 0) ? $urandom() : $urandom_range(40);
            send_req(op, pick_id(), TYPE_W'($urandom()), clock_s);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and special cases
        send_req(OP_GET_COUNT, '0, '0, '0);
        send_req(OP_CREATE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFF0);
        send_req(OP_CREATE, '0, 8'h00, '0);
        send_req(OP_GET_STATE, 32'd1, '0, '0);
        send_req(OP_GET_STATE, 32'hFFFF_FFFF, '0, '0);
        for (int i = 0; i < 33; i++) send_req(OP_ADD_CMD, 32'd1, '0, '0);
        send_req(OP_SEND, 32'd2, '0, 32'd5);
        send_req(OP_REPLY, 32'd1, '0, '0);
        send_req(OP_SCAN, '0, '0, 32'd10); // entry 2 not yet expired
        send_req(OP_SCAN, '0, '0, 32'd40);
        send_req(OP_CANCEL, 32'd2, '0, '0);
        send_req(OP_SCAN, '0, '0, 32'hFFFF_FFFF);
        send_req(4'd9, '0, '0, '0);
        send_req(4'd15, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_req(OP_CLEAR, '0, '0, '0);
        send_req(OP_GET_STATE, 32'd1, '0, '0);
        drain();

        // disabled, then re-enable resets ids
        write_cfg(REG_ENABLE, 0);
        send_req(OP_CREATE, '0, 8'h5A, '0);
        send_req(OP_GET_STATE, 32'd3, '0, '0);
        send_req(OP_CLEAR, '0, '0, '0);
        drain();
        write_cfg(REG_ENABLE, 1);

        // zero timeout: every pending entry expires at once; fill the table
        write_cfg(REG_TIMEOUT, 0);
        for (int i = 0; i < DEF_TABLE_DEPTH + 2; i++)
            send_req(OP_CREATE, '0, TYPE_W'(i), TIME_W'(i));
        send_req(OP_SCAN, '0, '0, '0);
        send_req(OP_GET_COUNT, '0, '0, '0);
        send_req(OP_CLEAR, '0, '0, '0);
        drain();

        write_cfg(REG_TIMEOUT, 32'hFFFF_FFFF);
        req_idle_pct = 0; rsp_idle_pct = 0;
        random_phase(300);
        drain();

        // long receiver hold-off while requests keep coming
        write_cfg(REG_TIMEOUT, 20000);
        req_idle_pct = 21; rsp_idle_pct = 21;
        rsp_hold = 400;
        random_phase(380);
        drain();

        write_cfg(REG_TIMEOUT, DEF_TIMEOUT_MS);
        random_phase(380);
        // sender pause until all responses are back
        req_if.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        random_phase(380);
        drain();

        $display("Sent %0d requests, checked %0d responses, %0d entries timed out.",
                 sent, sb.checked, sb.expired_seen);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("Timeout waiting for responses");
        $display("Test completed with failures");
        $finish;
    end
endmodule
